FILE: rtl/kpt_pkg.sv
// shared constants, codes and types of the keyed pool table
package kpt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int MAX_FD      = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int FD_W        = $clog2(MAX_FD);
    localparam int FDADDR_W    = SLOT_W + FD_W;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_STAGE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD       = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] rel;
        logic [31:0] qry;
        logic [31:0] pkey;
        logic [4:0]  cnt;
    } slot_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_t             entry;
    } slot_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } slot_clr_t;

endpackage

FILE: rtl/kpt_slot_mem.sv
// slot key store: synchronous memory plus per-slot valid bits
module kpt_slot_mem
    import kpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output slot_t             rd_data,
    input  slot_wr_t          wr,
    input  slot_clr_t         clr
);

    slot_t                  mem [TABLE_SLOTS];
    slot_t                  data_rd_reg;
    logic                   vld_rd_reg;
    logic [TABLE_SLOTS-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            data_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (clr.en)
            begin
                vld_reg[clr.addr] <= 1'b0;
            end
            if (rd_en)
            begin
                vld_rd_reg <= vld_reg[rd_addr];
            end
        end
    end

    // an unwritten or cleared slot reads as all zero, i.e. empty
    assign rd_data = vld_rd_reg ? data_rd_reg : '0;

`ifndef SYNTHESIS
    a_no_wr_clr: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.en && clr.en))
        else $error("slot write and clear in the same cycle");

    a_no_rd_during_update: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !(wr.en || clr.en))
        else $error("slot scan overlaps an update");

    a_no_empty_key_wr: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (wr.entry.rel != 32'd0) || (wr.entry.qry != 32'd0))
        else $error("empty key written into a slot");
`endif

endmodule

FILE: rtl/keyed_pool_table.sv
// keyed pool table top level: command sequencer, descriptor stores, output register
// stage and rejected items go straight to the response state, which loads their beat when the output is free
// find/insert/delete scan cap = min(capacity_limit, 64) slots at one slot per cycle
// from the slot memory port, then a read and a write or output state per copied or returned descriptor
// one item at a time; the next item is taken once the last beat is in the output register
// reset clears the slot valid bits and used count at once; no clearing pass is needed
module keyed_pool_table
    import kpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration: capacity_limit
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [31:0]        relation_id,
    input  logic [31:0]        query_number,
    input  logic signed [31:0] pool_key,
    input  logic [4:0]         fd_count,
    input  logic [3:0]         fd_slot,
    input  logic [30:0]        fd_value,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] found_pool_key,
    output logic [4:0]         found_fd_count,
    output logic [3:0]         fd_position,
    output logic [30:0]        fd_out,
    output logic               fd_out_valid,
    output logic [6:0]         entries_in_use,
    output logic               last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_COPY_RD,
        S_COPY_WR,
        S_FIND_RD,
        S_FIND_OUT,
        S_RESP
    } state_t;

    localparam logic [6:0] CAP_MAX   = 7'(TABLE_SLOTS);
    localparam logic [4:0] MAX_FD_C  = 5'(MAX_FD);

    // sequencer state
    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [31:0]       rel_reg;
    logic [31:0]       qry_reg;
    logic [31:0]       pkey_reg;
    logic [4:0]        cnt_reg;
    logic [6:0]        cap_reg;
    logic [6:0]        used_reg;

    // scan bookkeeping
    logic [6:0]        issue_reg;
    logic              pend_reg;
    logic [SLOT_W-1:0] pend_idx_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [31:0]       hit_key_reg;
    logic [4:0]        hit_cnt_reg;
    logic              empty_found_reg;
    logic [SLOT_W-1:0] empty_idx_reg;

    // descriptor walk and single-beat response
    logic [FD_W-1:0]   pos_reg;
    status_t           status_reg;
    logic [31:0]       resp_key_reg;

    // output register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [31:0]       out_key_reg;
    logic [4:0]        out_cnt_reg;
    logic [3:0]        out_pos_reg;
    logic [30:0]       out_fd_reg;
    logic              out_fd_valid_reg;
    logic [6:0]        out_used_reg;
    logic              out_last_reg;

    // descriptor memories
    logic [30:0]       stage_mem [MAX_FD];
    logic [30:0]       fd_mem [TABLE_SLOTS * MAX_FD];
    logic [30:0]       stage_rd_reg;
    logic [30:0]       fd_rd_reg;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic [6:0]        eff_cap;
    logic              scan_rd;
    logic              empty_key;
    logic              pos_last;
    logic              stage_wr;
    logic              ins_ok;
    slot_t             slot_rd;
    slot_wr_t          slot_wr;
    slot_clr_t         slot_clr;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // a new beat goes into the output register
    assign out_load  = ((state_reg == S_FIND_OUT) || (state_reg == S_RESP)) && out_free;

    // capacity above the build saturates
    assign eff_cap   = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    assign scan_rd   = (state_reg == S_SCAN) && (issue_reg < eff_cap);
    assign empty_key = (relation_id == 32'd0) && (query_number == 32'd0);

    // last descriptor of a copy or a find walk
    assign pos_last  = ((5'(pos_reg) + 5'd1) == ((cmd_reg == CMD_FIND) ? hit_cnt_reg : cnt_reg));

    assign stage_wr  = in_accept && (cmd_t'(cmd) == CMD_STAGE) && ({1'b0, fd_slot} < MAX_FD_C);

    // insert succeeds: no match, room in the count and a free slot seen
    assign ins_ok    = !hit_reg && (used_reg < eff_cap) && empty_found_reg;

    always_comb
    begin
        slot_wr.en         = (state_reg == S_DECIDE) && (cmd_reg == CMD_INSERT) && ins_ok;
        slot_wr.addr       = empty_idx_reg;
        slot_wr.entry.rel  = rel_reg;
        slot_wr.entry.qry  = qry_reg;
        slot_wr.entry.pkey = pkey_reg;
        slot_wr.entry.cnt  = cnt_reg;
        slot_clr.en        = (state_reg == S_DECIDE) && (cmd_reg == CMD_DELETE) && hit_reg;
        slot_clr.addr      = hit_idx_reg;
    end

    kpt_slot_mem u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (scan_rd),
        .rd_addr (issue_reg[SLOT_W-1:0]),
        .rd_data (slot_rd),
        .wr      (slot_wr),
        .clr     (slot_clr)
    );

    // staging buffer and per-slot descriptor store
    always_ff @(posedge clk)
    begin
        if (stage_wr)
        begin
            stage_mem[fd_slot[FD_W-1:0]] <= fd_value;
        end
        if (state_reg == S_COPY_RD)
        begin
            stage_rd_reg <= stage_mem[pos_reg];
        end
        if (state_reg == S_COPY_WR)
        begin
            fd_mem[{empty_idx_reg, pos_reg}] <= stage_rd_reg;
        end
        if (state_reg == S_FIND_RD)
        begin
            fd_rd_reg <= fd_mem[{hit_idx_reg, pos_reg}];
        end
    end

    // payload registers: captured on acceptance
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= cmd_t'(cmd);
            rel_reg  <= relation_id;
            qry_reg  <= query_number;
            pkey_reg <= pool_key;
            cnt_reg  <= fd_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cap_reg          <= CAP_MAX;
            used_reg         <= '0;
            issue_reg        <= '0;
            pend_reg         <= 1'b0;
            pend_idx_reg     <= '0;
            hit_reg          <= 1'b0;
            hit_idx_reg      <= '0;
            hit_key_reg      <= '0;
            hit_cnt_reg      <= '0;
            empty_found_reg  <= 1'b0;
            empty_idx_reg    <= '0;
            pos_reg          <= '0;
            status_reg       <= ST_OK;
            resp_key_reg     <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= ST_OK;
            out_key_reg      <= '0;
            out_cnt_reg      <= '0;
            out_pos_reg      <= '0;
            out_fd_reg       <= '0;
            out_fd_valid_reg <= 1'b0;
            out_used_reg     <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end

            // output beat loaded, or taken downstream
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        resp_key_reg    <= '0;
                        issue_reg       <= '0;
                        pend_reg        <= 1'b0;
                        hit_reg         <= 1'b0;
                        empty_found_reg <= 1'b0;
                        pos_reg         <= '0;
                        if (cmd_t'(cmd) == CMD_STAGE)
                        begin
                            status_reg <= ({1'b0, fd_slot} < MAX_FD_C) ? ST_OK : ST_BAD;
                            state_reg  <= S_RESP;
                        end
                        else if (empty_key ||
                                 ((cmd_t'(cmd) == CMD_INSERT) && (fd_count > MAX_FD_C)))
                        begin
                            status_reg <= ST_BAD;
                            state_reg  <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    // one slot read issued per cycle, compared once its registered read data returns
                    if (scan_rd)
                    begin
                        issue_reg <= issue_reg + 7'd1;
                    end
                    pend_reg     <= scan_rd;
                    pend_idx_reg <= issue_reg[SLOT_W-1:0];
                    if (pend_reg)
                    begin
                        if (!hit_reg && (slot_rd.rel == rel_reg) && (slot_rd.qry == qry_reg))
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= pend_idx_reg;
                            hit_key_reg <= slot_rd.pkey;
                            hit_cnt_reg <= slot_rd.cnt;
                        end
                        if (!empty_found_reg && (slot_rd.rel == 32'd0) && (slot_rd.qry == 32'd0))
                        begin
                            empty_found_reg <= 1'b1;
                            empty_idx_reg   <= pend_idx_reg;
                        end
                    end
                    if (!scan_rd && !pend_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    unique case (cmd_reg)
                        CMD_FIND:
                        begin
                            if (!hit_reg)
                            begin
                                status_reg <= ST_NOT_FOUND;
                                state_reg  <= S_RESP;
                            end
                            else if (hit_cnt_reg == 5'd0)
                            begin
                                status_reg   <= ST_OK;
                                resp_key_reg <= hit_key_reg;
                                state_reg    <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_FIND_RD;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                status_reg <= ST_PRESENT;
                                state_reg  <= S_RESP;
                            end
                            else if (!ins_ok)
                            begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                used_reg   <= used_reg + 7'd1;
                                status_reg <= ST_OK;
                                state_reg  <= (cnt_reg == 5'd0) ? S_RESP : S_COPY_RD;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (hit_reg)
                            begin
                                if (used_reg != 7'd0)
                                begin
                                    used_reg <= used_reg - 7'd1;
                                end
                                status_reg <= ST_OK;
                            end
                            else
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                            state_reg <= S_RESP;
                        end
                        default:
                        begin
                            state_reg <= S_RESP;
                        end
                    endcase
                end

                S_COPY_RD:
                begin
                    state_reg <= S_COPY_WR;
                end

                S_COPY_WR:
                begin
                    pos_reg   <= pos_reg + 1'b1;
                    state_reg <= pos_last ? S_RESP : S_COPY_RD;
                end

                S_FIND_RD:
                begin
                    state_reg <= S_FIND_OUT;
                end

                S_FIND_OUT:
                begin
                    // one beat per stored descriptor
                    if (out_free)
                    begin
                        out_status_reg   <= ST_OK;
                        out_key_reg      <= hit_key_reg;
                        out_cnt_reg      <= hit_cnt_reg;
                        out_pos_reg      <= 4'(pos_reg);
                        out_fd_reg       <= fd_rd_reg;
                        out_fd_valid_reg <= 1'b1;
                        out_used_reg     <= used_reg;
                        out_last_reg     <= pos_last;
                        pos_reg          <= pos_reg + 1'b1;
                        state_reg        <= pos_last ? S_IDLE : S_FIND_RD;
                    end
                end

                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_status_reg   <= status_reg;
                        out_key_reg      <= resp_key_reg;
                        out_cnt_reg      <= '0;
                        out_pos_reg      <= '0;
                        out_fd_reg       <= '0;
                        out_fd_valid_reg <= 1'b0;
                        out_used_reg     <= used_reg;
                        out_last_reg     <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found_pool_key = out_key_reg;
    assign found_fd_count = out_cnt_reg;
    assign fd_position    = out_pos_reg;
    assign fd_out         = out_fd_reg;
    assign fd_out_valid   = out_fd_valid_reg;
    assign entries_in_use = out_used_reg;
    assign last           = out_last_reg;

`ifndef SYNTHESIS
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CAP_MAX)
        else $error("used count above table size");

    a_fd_beat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fd_out_valid |-> status == ST_OK)
        else $error("descriptor beat with failing status");

    a_nonlast_is_fd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> fd_out_valid)
        else $error("non-final beat without a descriptor");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken before the first finished");
`endif

endmodule
